/* rtl/hlic_pkg.sv */
// Shared types and constants of the HSL lightness inversion color core.
// Used by every module under rtl/ except hlic_div; depends on nothing else.
package hlic_pkg;

	// Width of a packed color: red 7:0, green 15:8, blue 23:16
	localparam int COLOR_W = 24;

	// Default number of fraction bits of the fixed-point datapath
	localparam int FRACTION_BITS_DEF = 16;

	// Register reset values
	localparam logic [COLOR_W-1:0] TEXT_COLOR_RST       = 24'hE0E0E0;
	localparam logic [COLOR_W-1:0] BACKGROUND_COLOR_RST = 24'h323232;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_TEXT       = 1'b0,
		REG_BACKGROUND = 1'b1
	} cfg_reg_t;

	// Divider operand widths and the lightness numerator width
	localparam int LI_NUM_W  = 9;
	localparam int SAT_NUM_W = 12;
	localparam int SAT_DEN_W = 12;
	localparam int HUE_NUM_W = 11;
	localparam int HUE_DEN_W = 8;

	// Special-case marks that travel with a transaction
	typedef struct packed {
		logic black;
		logic white;
	} flags_t;

endpackage

/* rtl/hlic_front.sv */
// Input stage: channel min/max, lightness, saturation and hue operands.
// Depends on hlic_pkg.
module hlic_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   source_valid,
	input  logic [hlic_pkg::COLOR_W-1:0]           source_color,
	output logic                                   valid_s1,
	output hlic_pkg::flags_t                       flags_s1,
	output logic [hlic_pkg::LI_NUM_W-1:0]          li_num_s1,
	output logic [hlic_pkg::SAT_NUM_W-1:0]         sat_num_s1,
	output logic [hlic_pkg::SAT_DEN_W-1:0]         sat_den_s1,
	output logic [hlic_pkg::HUE_NUM_W-1:0]         hue_num_s1,
	output logic [hlic_pkg::HUE_DEN_W-1:0]         hue_den_s1
);

	logic [7:0]  r, g, b, mx, mn, d;
	logic [8:0]  sum, den;
	logic [10:0] d11, hn;
	hlic_pkg::flags_t flags;

	assign r = source_color[7:0];
	assign g = source_color[15:8];
	assign b = source_color[23:16];

	// extremes, ties resolved red first then green
	always_comb begin
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
	end

	assign d   = mx - mn;
	assign d11 = {3'b0, d};
	assign sum = {1'b0, mx} + {1'b0, mn};
	assign den = (sum < 9'd255) ? sum : 9'd510 - sum;

	// hue numerator, six sectors of d each
	always_comb begin
		if (mx == r) begin
			hn = (g >= b) ? {3'b0, g - b} : 11'd6 * d11 - {3'b0, b - g};
		end else if (mx == g) begin
			hn = 11'd2 * d11 + {3'b0, b} - {3'b0, r};
		end else begin
			hn = 11'd4 * d11 + {3'b0, r} - {3'b0, g};
		end
	end

	assign flags.black = (source_color == '0);
	assign flags.white = (source_color == '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= source_valid;
		end
	end

	// grey colors get a unit divisor and zero numerators
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1   <= flags;
			li_num_s1  <= 9'd510 - sum;
			sat_num_s1 <= 12'd9 * {4'b0, d};
			sat_den_s1 <= (d == 8'd0) ? 12'd1 : 12'd10 * {3'b0, den};
			hue_num_s1 <= (d == 8'd0) ? 11'd0 : hn;
			hue_den_s1 <= (d == 8'd0) ? 8'd1 : d;
		end
	end

endmodule

/* rtl/hlic_div.sv */
// Pipelined restoring divider: quo = (num << FB) / den, one quotient bit per stage.
// Depends on nothing; the quotient must fit in QW bits.
module hlic_div #(
	parameter int NW = 9,
	parameter int DW = 9,
	parameter int QW = 19,
	parameter int FB = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	localparam int XW = NW + FB;

	logic [NW-1:0] num_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] quo_s [QW];

	genvar i;
	for (i = 0; i < QW; i++) begin : g_stage
		logic [NW-1:0] num_in;
		logic [DW-1:0] den_in, rem_in;
		logic [QW-1:0] quo_in;
		logic [XW-1:0] x_in;
		logic [DW:0]   trial;
		logic          take;

		if (i == 0) begin : g_first
			assign num_in = num;
			assign den_in = den;
			assign quo_in = '0;
			assign rem_in = DW'(x_in >> QW);
		end else begin : g_next
			assign num_in = num_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
			assign rem_in = rem_s[i-1];
		end

		// shift in the next dividend bit and try a subtract
		assign x_in  = {num_in, {FB{1'b0}}};
		assign trial = {rem_in, x_in[QW-1-i]};
		assign take  = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i] <= num_in;
				den_s[i] <= den_in;
				rem_s[i] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
				quo_s[i] <= {quo_in[QW-2:0], take};
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule

/* rtl/hlic_back.sv */
// HSL to RGB back end: q/p terms, per-channel hue ramps, scaling to 8 bits.
// Depends on hlic_pkg.
module hlic_back #(
	parameter int FB = hlic_pkg::FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_in,
	input  hlic_pkg::flags_t             flags_in,
	input  logic [FB:0]                  li,
	input  logic [FB-1:0]                sat,
	input  logic [FB+2:0]                hue,
	input  logic [hlic_pkg::COLOR_W-1:0] text_color,
	input  logic [hlic_pkg::COLOR_W-1:0] background_color,
	output logic                         dark_valid,
	output logic [hlic_pkg::COLOR_W-1:0] dark_color
);

	localparam int TW = FB + 4;
	localparam logic [TW-1:0] ONE_T = TW'(1) << FB;
	localparam logic [FB:0]   HALF  = (FB+1)'(1) << (FB - 1);

	// stage 1: li * s
	logic [2*FB:0]      ls_prod;
	logic               valid_s1, valid_s2, valid_s3;
	hlic_pkg::flags_t   flags_s1, flags_s2, flags_s3;
	logic [FB:0]        li_s1;
	logic [FB-1:0]      sat_s1, m_s1;
	logic [FB+2:0]      hue_s1;

	assign ls_prod = (2*FB+1)'(li) * (2*FB+1)'(sat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			dark_valid <= 1'b0;
		end else if (en) begin
			valid_s1   <= valid_in;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			dark_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1 <= flags_in;
			li_s1    <= li;
			sat_s1   <= sat;
			m_s1     <= ls_prod[2*FB-1:FB];
			hue_s1   <= hue;
		end
	end

	// stage 2: q, p and per-channel ramp selection
	logic [FB+1:0] q_w, p_w;
	logic [FB:0]   q, p, diff;
	logic [FB:0]   diff_s2;
	logic [FB:0]   base_s2 [3];
	logic [FB:0]   w_s2 [3];
	logic [FB:0]   val_s3 [3];

	// zero saturation gives q == p == li, so every channel is li
	always_comb begin
		if (li_s1 < HALF) begin
			q_w = (FB+2)'(li_s1) + (FB+2)'(m_s1);
		end else begin
			q_w = (FB+2)'(li_s1) + (FB+2)'(sat_s1) - (FB+2)'(m_s1);
		end
		q    = q_w[FB:0];
		p_w  = {li_s1, 1'b0} - (FB+2)'(q);
		p    = p_w[FB:0];
		diff = q - p;
	end

	genvar c;
	for (c = 0; c < 3; c++) begin : g_chan
		// hue offsets: red +2, green 0, blue +4 (units of ONE)
		localparam logic [TW-1:0] OFS = (c == 0) ? TW'(2) * ONE_T :
			(c == 1) ? TW'(0) : TW'(4) * ONE_T;
		logic [TW-1:0] t_raw, t;
		logic [FB:0]   base, w;
		logic [2*FB+1:0] prod;

		assign t_raw = TW'(hue_s1) + OFS;
		assign t     = (t_raw >= TW'(6) * ONE_T) ? t_raw - TW'(6) * ONE_T : t_raw;

		always_comb begin
			if (t < ONE_T) begin
				base = p;
				w    = t[FB:0];
			end else if (t < TW'(3) * ONE_T) begin
				base = q;
				w    = '0;
			end else if (t < TW'(4) * ONE_T) begin
				base = p;
				w    = (FB+1)'(TW'(4) * ONE_T - t);
			end else begin
				base = p;
				w    = '0;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				base_s2[c] <= base;
				w_s2[c]    <= w;
			end
		end

		// stage 3: ramp value
		assign prod = (2*FB+2)'(diff_s2) * (2*FB+2)'(w_s2[c]);

		always_ff @(posedge clk) begin
			if (en) begin
				val_s3[c] <= base_s2[c] + prod[2*FB:FB];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s2 <= flags_s1;
			flags_s3 <= flags_s2;
			diff_s2  <= diff;
		end
	end

	// stage 4: scale by 255 and pick the special cases
	logic [FB+8:0] sc [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sc[k] = ((FB+9)'(val_s3[k]) << 8) - (FB+9)'(val_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (flags_s3.black) begin
				dark_color <= text_color;
			end else if (flags_s3.white) begin
				dark_color <= background_color;
			end else begin
				dark_color <= {sc[2][FB+7:FB], sc[1][FB+7:FB], sc[0][FB+7:FB]};
			end
		end
	end

endmodule

/* rtl/hsl_lightness_invert_color_core.sv */
// Dark-mode color mapper. One 24-bit color (red 7:0, green 15:8, blue 23:16) enters per
// cycle on source_valid/source_stall while not stalled; its dark-mode color leaves on
// dark_valid/dark_stall after one input stage, FRACTION_BITS + 3 stages of the
// bit-per-stage saturation and hue dividers (lightness runs beside them as a reciprocal
// multiply), and four back-end stages. Black maps to text_color, white to
// background_color; other colors have lightness inverted and saturation scaled by 0.9.
// A stall at the output freezes the whole pipeline. Write registers only while idle.
module hsl_lightness_invert_color_core #(
	parameter int FRACTION_BITS = hlic_pkg::FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [hlic_pkg::COLOR_W-1:0] cfg_data,
	input  logic                         source_valid,
	output logic                         source_stall,
	input  logic [hlic_pkg::COLOR_W-1:0] source_color,
	output logic                         dark_valid,
	input  logic                         dark_stall,
	output logic [hlic_pkg::COLOR_W-1:0] dark_color
);

	localparam int FB = FRACTION_BITS;
	localparam int QW = FB + 3;

	// lightness constants: n << FB / 510 == n * A + (n * B) / 255
	localparam logic [FB:0] LI_A = (FB+1)'((64'd1 << (FB - 1)) / 255);
	localparam logic [16:0] LI_B = 17'((64'd1 << (FB - 1)) % 255);
	// ceil(2^25 / 255), exact for numerators below 2^17
	localparam logic [34:0] LI_M = 35'(131587);

	logic en;
	logic [hlic_pkg::COLOR_W-1:0] text_color_q, background_color_q;

	// pipeline advances unless a finished transaction is held
	assign en           = !dark_valid || !dark_stall;
	assign source_stall = !en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q       <= hlic_pkg::TEXT_COLOR_RST;
			background_color_q <= hlic_pkg::BACKGROUND_COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hlic_pkg::REG_TEXT:       text_color_q       <= cfg_data;
				hlic_pkg::REG_BACKGROUND: background_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front stage
	logic                               valid_s1;
	hlic_pkg::flags_t                   flags_s1;
	logic [hlic_pkg::LI_NUM_W-1:0]      li_num_s1;
	logic [hlic_pkg::SAT_NUM_W-1:0]     sat_num_s1;
	logic [hlic_pkg::SAT_DEN_W-1:0]     sat_den_s1;
	logic [hlic_pkg::HUE_NUM_W-1:0]     hue_num_s1;
	logic [hlic_pkg::HUE_DEN_W-1:0]     hue_den_s1;

	hlic_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.source_valid (source_valid),
		.source_color (source_color),
		.valid_s1     (valid_s1),
		.flags_s1     (flags_s1),
		.li_num_s1    (li_num_s1),
		.sat_num_s1   (sat_num_s1),
		.sat_den_s1   (sat_den_s1),
		.hue_num_s1   (hue_num_s1),
		.hue_den_s1   (hue_den_s1)
	);

	// lightness by reciprocal multiply, then delayed to line up with the dividers
	logic [FB:0]   li_a_s2;
	logic [16:0]   li_y_s2;
	logic [34:0]   li_prod;
	logic [FB:0]   li_dly_s [QW-1];

	assign li_prod = 35'(li_y_s2) * LI_M;

	always_ff @(posedge clk) begin
		if (en) begin
			li_a_s2     <= (FB+1)'(li_num_s1) * LI_A;
			li_y_s2     <= 17'(li_num_s1) * LI_B;
			li_dly_s[0] <= li_a_s2 + (FB+1)'(li_prod[34:25]);
			for (int k = 1; k < QW - 1; k++) li_dly_s[k] <= li_dly_s[k-1];
		end
	end

	// dividers
	logic [QW-1:0] sat_quo, hue_quo;

	hlic_div #(
		.NW (hlic_pkg::SAT_NUM_W), .DW (hlic_pkg::SAT_DEN_W), .QW (QW), .FB (FB)
	) u_div_sat (
		.clk (clk), .en (en), .num (sat_num_s1), .den (sat_den_s1), .quo (sat_quo)
	);

	hlic_div #(
		.NW (hlic_pkg::HUE_NUM_W), .DW (hlic_pkg::HUE_DEN_W), .QW (QW), .FB (FB)
	) u_div_hue (
		.clk (clk), .en (en), .num (hue_num_s1), .den (hue_den_s1), .quo (hue_quo)
	);

	// valid and flags ride alongside the dividers
	logic             side_valid_s [QW];
	hlic_pkg::flags_t side_flags_s [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) side_valid_s[k] <= 1'b0;
		end else if (en) begin
			side_valid_s[0] <= valid_s1;
			for (int k = 1; k < QW; k++) side_valid_s[k] <= side_valid_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_flags_s[0] <= flags_s1;
			for (int k = 1; k < QW; k++) side_flags_s[k] <= side_flags_s[k-1];
		end
	end

	// back end
	hlic_back #(
		.FB (FB)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.valid_in         (side_valid_s[QW-1]),
		.flags_in         (side_flags_s[QW-1]),
		.li               (li_dly_s[QW-2]),
		.sat              (sat_quo[FB-1:0]),
		.hue              (hue_quo),
		.text_color       (text_color_q),
		.background_color (background_color_q),
		.dark_valid       (dark_valid),
		.dark_color       (dark_color)
	);

endmodule
